@@ rtl/tga_rle_pkg.sv @@
// Package for the TGA pixel data decoder: field widths, action, status and
// register index codes, and the channel swizzle function. No dependencies.
`timescale 1ns / 1ps

package tga_rle_pkg;

  // Default largest image side
  localparam int MAX_SIDE_DEF = 1024 * 16;

  // Fixed field widths
  localparam int SIDE_W   = 15;   // width and height registers
  localparam int AREA_W   = 32;   // row bases and pixel counts
  localparam int INDEX_W  = 28;   // destination pixel index
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 15;

  // Packet header fields
  localparam logic [7:0] RUN_BIT    = 8'b1000_0000;
  localparam logic [7:0] COUNT_MASK = 8'b0111_1111;

  // Input actions
  localparam logic [1:0] ACT_DATA = 2'd0;
  localparam logic [1:0] ACT_STEP = 2'd1;
  localparam logic [1:0] ACT_END  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_TRUNCATE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RLE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP     = 3'd4;

  // Reorder stored B,G,R,A bytes into R,G,B,A channel order
  function automatic logic [31:0] swizzle(input logic [31:0] b, input logic [2:0] n);
    logic [31:0] v;
    unique case (n)
      3'd1:    v = {24'd0, b[7:0]};
      3'd2:    v = {16'd0, b[7:0], b[15:8]};
      3'd3:    v = {8'd0, b[7:0], b[15:8], b[23:16]};
      default: v = {b[31:24], b[7:0], b[15:8], b[23:16]};
    endcase
    return v;
  endfunction

endpackage

@@ rtl/tga_rle_pixel_decoder.sv @@
// TGA pixel data decoder: raw/run-length packets, swizzle, destination index.
// An accepted input beat passes the input stage and the result register.
// Throughput: one beat per cycle unless out_stall holds a result; the packet
// and position state updates once per beat; (height-1)*width is registered.
// Reset (rst_n low, synchronous) restores register defaults and clears state.
// Depends on tga_rle_pkg.
`timescale 1ns / 1ps

module tga_rle_pixel_decoder
  import tga_rle_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // config write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_action,
  input  logic [7:0]           in_data_byte,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_pixel_valid,
  output logic [INDEX_W-1:0]   out_pixel_index,
  output logic [31:0]          out_pixel_value,
  output logic                 out_run_pending,
  output logic                 out_image_done,
  output logic [1:0]           out_status
);

  // column/row counter width
  localparam int CNT_W = (MAX_SIDE <= 1) ? 1 :
                         (MAX_SIDE > 32768) ? SIDE_W : $clog2(MAX_SIDE);

  // config registers
  logic [2:0]        chan_r;
  logic [SIDE_W-1:0] width_r, height_r;
  logic              rle_r, flip_r;
  logic [AREA_W-1:0] last_base_r;   // (height - 1) * width

  // input stage
  logic       s1_vld_r;
  logic [1:0] s1_action_r;
  logic [7:0] s1_byte_r;

  // decoder state
  logic              eh_r, eh_nxt;
  logic [1:0]        bp_r, bp_nxt;
  logic [23:0]       partial_r, partial_nxt;
  logic [6:0]        prem_r, prem_nxt;
  logic              pir_r, pir_nxt;
  logic [6:0]        rp_r, rp_nxt;
  logic [31:0]       held_r, held_nxt;
  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt;
  logic [AREA_W-1:0] base_r, base_nxt;   // row * width
  logic              fin_r, fin_nxt;

  // result register
  logic               out_valid_r;
  logic               out_pv_r, out_pv_nxt;
  logic [INDEX_W-1:0] out_idx_r, out_idx_nxt;
  logic [31:0]        out_val_r, out_val_nxt;
  logic               out_rp_r;
  logic               out_done_r;
  logic [1:0]         out_status_r, out_status_nxt;

  // effective register values
  logic [2:0]        eff_n;
  logic [SIDE_W-1:0] eff_w, eff_h;
  logic [29:0]       area_prod;

  always_comb begin
    if (chan_r == 3'd0) eff_n = 3'd1;
    else if (chan_r > 3'd4) eff_n = 3'd4;
    else eff_n = chan_r;

    if (width_r == '0) eff_w = SIDE_W'(1);
    else if (32'(width_r) > 32'(MAX_SIDE)) eff_w = SIDE_W'(MAX_SIDE);
    else eff_w = width_r;

    if (height_r == '0) eff_h = SIDE_W'(1);
    else if (32'(height_r) > 32'(MAX_SIDE)) eff_h = SIDE_W'(MAX_SIDE);
    else eff_h = height_r;
  end

  assign area_prod = 30'(eff_h - SIDE_W'(1)) * 30'(eff_w);

  // handshake
  logic adv, fire;
  assign adv      = !out_valid_r || !out_stall;
  assign fire     = s1_vld_r && adv;
  assign in_stall = !rst_n || (s1_vld_r && !adv);

  // index, pixels left and byte assembly
  logic [AREA_W-1:0] idx, left;
  logic [31:0]       all_bytes, asm_value;
  logic [SIDE_W:0]   col_inc, row_inc;

  always_comb begin
    if (flip_r) idx = last_base_r - base_r + AREA_W'(col_r);
    else idx = base_r + AREA_W'(col_r);
    left      = last_base_r - base_r + AREA_W'(eff_w) - AREA_W'(col_r);
    all_bytes = {8'd0, partial_r} | (32'(s1_byte_r) << {bp_r, 3'b000});
    asm_value = swizzle(all_bytes, eff_n);
    col_inc   = (SIDE_W+1)'(col_r) + (SIDE_W+1)'(1);
    row_inc   = (SIDE_W+1)'(row_r) + (SIDE_W+1)'(1);
  end

  // next state for the beat in the input stage
  always_comb begin
    logic px;
    eh_nxt = eh_r;  bp_nxt = bp_r;  partial_nxt = partial_r;
    prem_nxt = prem_r;  pir_nxt = pir_r;  rp_nxt = rp_r;
    held_nxt = held_r;  col_nxt = col_r;  row_nxt = row_r;
    base_nxt = base_r;  fin_nxt = fin_r;
    px = 1'b0;
    out_val_nxt = '0;
    out_status_nxt = ST_OK;

    unique case (s1_action_r)
      ACT_DATA: begin
        if (!fin_r) begin
          if (rp_r != '0) begin
            out_status_nxt = ST_REJECT;
          end else if (rle_r && eh_r) begin
            // packet header
            pir_nxt  = (s1_byte_r & RUN_BIT) != 8'd0;
            prem_nxt = 7'(s1_byte_r & COUNT_MASK);
            eh_nxt   = 1'b0;
          end else if (3'(bp_r) + 3'd1 < eff_n) begin
            partial_nxt = all_bytes[23:0];
            bp_nxt      = bp_r + 2'd1;
          end else begin
            // last byte of a pixel
            px          = 1'b1;
            out_val_nxt = asm_value;
            partial_nxt = '0;
            bp_nxt      = '0;
            if (rle_r) begin
              if (pir_r) begin
                held_nxt = asm_value;
                rp_nxt   = prem_r;
                prem_nxt = '0;
                if (prem_r == '0) eh_nxt = 1'b1;
              end else if (prem_r == '0) begin
                eh_nxt = 1'b1;
              end else begin
                prem_nxt = prem_r - 7'd1;
              end
            end
          end
        end
      end
      ACT_STEP: begin
        if (!fin_r && rp_r != '0) begin
          px          = 1'b1;
          out_val_nxt = held_r;
          rp_nxt      = rp_r - 7'd1;
          if (rp_r == 7'd1) eh_nxt = 1'b1;
        end
      end
      ACT_END: begin
        if (!fin_r && AREA_W'(rp_r) < left) out_status_nxt = ST_TRUNCATE;
      end
      default: ;
    endcase

    // advance the write position after a pixel
    if (px) begin
      if (col_inc >= {1'b0, eff_w}) begin
        col_nxt = '0;
        if (row_inc >= {1'b0, eff_h}) begin
          row_nxt  = '0;
          base_nxt = '0;
          fin_nxt  = 1'b1;
          rp_nxt   = '0;
          eh_nxt   = 1'b0;
        end else begin
          row_nxt  = row_inc[CNT_W-1:0];
          base_nxt = base_r + AREA_W'(eff_w);
        end
      end else begin
        col_nxt = col_inc[CNT_W-1:0];
      end
    end

    out_pv_nxt  = px;
    out_idx_nxt = px ? idx[INDEX_W-1:0] : '0;
  end

  // config, restart and decoder state
  logic cfg_hit, cfg_rle_new;
  assign cfg_hit     = cfg_we && (cfg_index <= CFG_FLIP);
  assign cfg_rle_new = (cfg_index == CFG_RLE) ? cfg_data[0] : rle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= 3'd4;  width_r <= SIDE_W'(1);  height_r <= SIDE_W'(1);
      rle_r <= 1'b0;  flip_r <= 1'b0;
      eh_r <= 1'b0;  bp_r <= '0;  partial_r <= '0;  prem_r <= '0;
      pir_r <= 1'b0;  rp_r <= '0;  held_r <= '0;  col_r <= '0;
      row_r <= '0;  base_r <= '0;  fin_r <= 1'b0;
      last_base_r <= '0;
    end else begin
      last_base_r <= {2'b00, area_prod};
      if (cfg_hit) begin
        unique case (cfg_index)
          CFG_CHANNELS: chan_r   <= cfg_data[2:0];
          CFG_WIDTH:    width_r  <= cfg_data;
          CFG_HEIGHT:   height_r <= cfg_data;
          CFG_RLE:      rle_r    <= cfg_data[0];
          default:      flip_r   <= cfg_data[0];
        endcase
        // restart decoding
        eh_r <= cfg_rle_new;  bp_r <= '0;  partial_r <= '0;  prem_r <= '0;
        pir_r <= 1'b0;  rp_r <= '0;  held_r <= '0;  col_r <= '0;
        row_r <= '0;  base_r <= '0;  fin_r <= 1'b0;
      end else if (fire) begin
        eh_r <= eh_nxt;  bp_r <= bp_nxt;  partial_r <= partial_nxt;
        prem_r <= prem_nxt;  pir_r <= pir_nxt;  rp_r <= rp_nxt;
        held_r <= held_nxt;  col_r <= col_nxt;  row_r <= row_nxt;
        base_r <= base_nxt;  fin_r <= fin_nxt;
      end
    end
  end

  // input stage and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) s1_vld_r <= in_valid;
      if (adv) out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_action_r <= in_action;
      s1_byte_r   <= in_data_byte;
    end
    if (fire) begin
      out_pv_r     <= out_pv_nxt;
      out_idx_r    <= out_idx_nxt;
      out_val_r    <= out_val_nxt;
      out_rp_r     <= rp_nxt != '0;
      out_done_r   <= fin_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_valid = out_pv_r;
  assign out_pixel_index = out_idx_r;
  assign out_pixel_value = out_val_r;
  assign out_run_pending = out_rp_r;
  assign out_image_done  = out_done_r;
  assign out_status      = out_status_r;

  // consistency checks
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> (rp_r == '0 && !eh_r))
    else $error("finished image still has repeats or header pending");

  a_raw_no_runs: assert property (@(posedge clk) disable iff (!rst_n)
    !rle_r |-> (rp_r == '0 && !eh_r))
    else $error("raw mode holds packet state");

  a_runs_no_header: assert property (@(posedge clk) disable iff (!rst_n)
    (rp_r != '0) |-> !eh_r)
    else $error("header expected while repeats pending");

  a_byte_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_we |=> ({1'b0, bp_r} < eff_n))
    else $error("byte position beyond channel count");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_we |=> ((SIDE_W+1)'(col_r) < {1'b0, eff_w}))
    else $error("column beyond image width");

endmodule

@@ test/tga_rle_decode_checker.sv @@
// Checker for the TGA pixel data decoder: follows config writes and accepted
// input beats, predicts each result beat and compares it field by field.
// Depends on tga_rle_pkg.
`timescale 1ns / 1ps

module tga_rle_decode_checker
  import tga_rle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [1:0]           in_action,
  input  logic [7:0]           in_data_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_pixel_valid,
  input  logic [INDEX_W-1:0]   out_pixel_index,
  input  logic [31:0]          out_pixel_value,
  input  logic                 out_run_pending,
  input  logic                 out_image_done,
  input  logic [1:0]           out_status,
  output int                   fail_count,
  output int                   pending_results,
  output int                   checked_count,
  output int                   pixel_count
);

  typedef struct packed {
    logic               pix_valid;
    logic [INDEX_W-1:0] index;
    logic [31:0]        value;
    logic               run_pend;
    logic               done;
    logic [1:0]         status;
  } decode_result_t;

  // Register copy
  logic [2:0]        reg_channels;
  logic [SIDE_W-1:0] reg_width;
  logic [SIDE_W-1:0] reg_height;
  logic              reg_rle;
  logic              reg_flip;

  // Decoder state
  logic        hdr_due;
  logic [1:0]  byte_slot;
  logic [23:0] byte_accum;
  logic [6:0]  pkt_left;
  logic        pkt_run;
  logic [6:0]  repeats_left;
  logic [31:0] run_pixel;
  int unsigned col_pos;
  int unsigned row_pos;
  logic        image_complete;

  decode_result_t decode_results_q[$];
  int fails;
  int checked;
  int pixels;

  function automatic int unsigned lanes();
    if (reg_channels == 3'd0) return 1;
    if (reg_channels > 3'd4) return 4;
    return 32'(reg_channels);
  endfunction

  function automatic int unsigned clamp_side(input logic [SIDE_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_SIDE_DEF) return MAX_SIDE_DEF;
    return 32'(v);
  endfunction

  // Stored order is B,G,R,A; results carry R,G,B,A from bit 0 up
  function automatic logic [31:0] reorder(input logic [31:0] raw, input int unsigned n);
    case (n)
      1:       return {24'd0, raw[7:0]};
      2:       return {16'd0, raw[7:0], raw[15:8]};
      3:       return {8'd0, raw[7:0], raw[15:8], raw[23:16]};
      default: return {raw[31:24], raw[7:0], raw[15:8], raw[23:16]};
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] place_index();
    int unsigned w;
    int unsigned h;
    int unsigned r;
    w = clamp_side(reg_width);
    h = clamp_side(reg_height);
    r = reg_flip ? (h - 1 - row_pos) : row_pos;
    return INDEX_W'(r * w + col_pos);
  endfunction

  task automatic restart_decode();
    hdr_due        = reg_rle;
    byte_slot      = '0;
    byte_accum     = '0;
    pkt_left       = '0;
    pkt_run        = 1'b0;
    repeats_left   = '0;
    run_pixel      = '0;
    col_pos        = 0;
    row_pos        = 0;
    image_complete = 1'b0;
  endtask

  // Next pixel position; the last one closes the image
  task automatic step_position();
    col_pos++;
    if (col_pos >= clamp_side(reg_width)) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= clamp_side(reg_height)) begin
        row_pos        = 0;
        image_complete = 1'b1;
        repeats_left   = '0;
        hdr_due        = 1'b0;
      end
    end
  endtask

  // A write to any defined register restarts decoding
  task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] val);
    case (idx)
      CFG_CHANNELS: reg_channels = val[2:0];
      CFG_WIDTH:    reg_width    = val[SIDE_W-1:0];
      CFG_HEIGHT:   reg_height   = val[SIDE_W-1:0];
      CFG_RLE:      reg_rle      = val[0];
      CFG_FLIP:     reg_flip     = val[0];
      default:      return;
    endcase
    restart_decode();
  endtask

  task automatic decode_beat(input logic [1:0] act, input logic [7:0] b,
                             output decode_result_t r);
    int unsigned n;
    int unsigned w;
    int unsigned h;
    int unsigned left;
    logic [31:0] word;
    r = '0;
    if (act == ACT_DATA && !image_complete) begin
      if (repeats_left != 0) begin
        r.status = ST_REJECT;
      end else if (reg_rle && hdr_due) begin
        pkt_run  = (b & RUN_BIT) != 0;
        pkt_left = 7'(b & COUNT_MASK);
        hdr_due  = 1'b0;
      end else begin
        n = lanes();
        if (byte_slot + 1 < n) begin
          byte_accum[8*byte_slot +: 8] = b;
          byte_slot++;
        end else begin
          word = {8'd0, byte_accum};
          word[8*byte_slot +: 8] = b;
          r.pix_valid = 1'b1;
          r.value     = reorder(word, n);
          r.index     = place_index();
          byte_accum  = '0;
          byte_slot   = '0;
          if (reg_rle) begin
            if (pkt_run) begin
              run_pixel    = r.value;
              repeats_left = pkt_left;
              pkt_left     = '0;
              if (repeats_left == 0) hdr_due = 1'b1;
            end else if (pkt_left == 0) begin
              hdr_due = 1'b1;
            end else begin
              pkt_left--;
            end
          end
          step_position();
        end
      end
    end else if (act == ACT_STEP && !image_complete && repeats_left != 0) begin
      r.pix_valid = 1'b1;
      r.value     = run_pixel;
      r.index     = place_index();
      repeats_left--;
      if (repeats_left == 0) hdr_due = 1'b1;
      step_position();
    end else if (act == ACT_END && !image_complete) begin
      // truncated unless the waiting repeats fill the rest of the image
      w    = clamp_side(reg_width);
      h    = clamp_side(reg_height);
      left = (h - 1 - row_pos) * w + (w - col_pos);
      if (repeats_left < left) r.status = ST_TRUNCATE;
    end
    r.run_pend = repeats_left != 0;
    r.done     = image_complete;
  endtask

  // Compare result beats, then track config and input beats
  always @(posedge clk) begin : watch
    decode_result_t want;
    decode_result_t fresh;
    if (!rst_n) begin
      reg_channels = 3'd4;
      reg_width    = SIDE_W'(1);
      reg_height   = SIDE_W'(1);
      reg_rle      = 1'b0;
      reg_flip     = 1'b0;
      restart_decode();
      decode_results_q.delete();
      fails   = 0;
      checked = 0;
      pixels  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decode_results_q.size() == 0) begin
          $error("result beat with nothing expected");
          fails++;
        end else begin
          want = decode_results_q.pop_front();
          checked++;
          if (want.pix_valid) pixels++;
          if (out_pixel_valid !== want.pix_valid) begin
            $error("pixel_valid: expected %0d, got %0d", want.pix_valid, out_pixel_valid);
            fails++;
          end
          if (out_pixel_index !== want.index) begin
            $error("pixel_index: expected %0h, got %0h", want.index, out_pixel_index);
            fails++;
          end
          if (out_pixel_value !== want.value) begin
            $error("pixel_value: expected %08h, got %08h", want.value, out_pixel_value);
            fails++;
          end
          if (out_run_pending !== want.run_pend) begin
            $error("run_pending: expected %0d, got %0d", want.run_pend, out_run_pending);
            fails++;
          end
          if (out_image_done !== want.done) begin
            $error("image_done: expected %0d, got %0d", want.done, out_image_done);
            fails++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fails++;
          end
        end
      end
      if (cfg_we) apply_cfg(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        decode_beat(in_action, in_data_byte, fresh);
        decode_results_q.push_back(fresh);
      end
    end
    fail_count      <= fails;
    pending_results <= decode_results_q.size();
    checked_count   <= checked;
    pixel_count     <= pixels;
  end

endmodule

@@ test/tga_rle_pixel_decoder_tb.sv @@
// Testbench top for the TGA pixel data decoder: clock, reset, config writes,
// byte stream stimulus, receiver stalls and the verdict.
// Depends on tga_rle_pkg, tga_rle_pixel_decoder and tga_rle_decode_checker.
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_tb;
  import tga_rle_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 150;
  localparam int CYCLE_LIMIT = 300000;
  localparam int BEAT_TARGET = 660;
  localparam int DRAIN_GAP   = 6;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_action = ACT_DATA;
  logic [7:0]           in_data_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_pixel_valid;
  logic [INDEX_W-1:0]   out_pixel_index;
  logic [31:0]          out_pixel_value;
  logic                 out_run_pending;
  logic                 out_image_done;
  logic [1:0]           out_status;

  int fail_count;
  int pending_results;
  int checked_count;
  int pixel_count;

  int cycle_count = 0;
  int beats_sent = 0;
  int phase = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  tga_rle_pixel_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_valid (out_pixel_valid),
    .out_pixel_index (out_pixel_index),
    .out_pixel_value (out_pixel_value),
    .out_run_pending (out_run_pending),
    .out_image_done  (out_image_done),
    .out_status      (out_status)
  );

  tga_rle_decode_checker decode_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_valid (out_pixel_valid),
    .out_pixel_index (out_pixel_index),
    .out_pixel_value (out_pixel_value),
    .out_run_pending (out_run_pending),
    .out_image_done  (out_image_done),
    .out_status      (out_status),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .checked_count   (checked_count),
    .pixel_count     (pixel_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tga_rle_pixel_decoder_tb failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic int side_of(input int v);
    if (v == 0) return 1;
    if (v > MAX_SIDE_DEF) return MAX_SIDE_DEF;
    return v;
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      0:       begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
      1:       begin send_idle_pct = 72; recv_stall_pct <= 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct <= 72; end
      default: begin send_idle_pct = 21; recv_stall_pct <= 21; end
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DAT_W'(val);
    @(posedge clk);
  endtask

  task automatic set_config(input int ch, input int w, input int h,
                            input int rle, input int flip);
    write_reg(CFG_CHANNELS, ch);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_RLE, rle);
    write_reg(CFG_FLIP, flip);
    cfg_we <= 1'b0;
  endtask

  // One input beat, held until accepted
  task automatic offer_beat(input logic [1:0] act, input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_data_byte <= data;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic offer_pixel(input int chans);
    for (int k = 0; k < chans; k++) offer_beat(ACT_DATA, 8'($urandom_range(255)));
  endtask

  // Stray beats: idle steps, early ends, the unused action, a loose byte
  task automatic offer_noise();
    int pick;
    pick = $urandom_range(7);
    if (pick < 3)      offer_beat(ACT_STEP, 8'($urandom_range(255)));
    else if (pick < 5) offer_beat(ACT_END, 8'($urandom_range(255)));
    else if (pick < 7) offer_beat(ACT_UNUSED, 8'($urandom_range(255)));
    else               offer_beat(ACT_DATA, 8'($urandom_range(255)));
  endtask

  // Well-formed pixel stream for `target` pixels, then end of data
  task automatic feed_image(input int chans, input int target, input bit rle);
    int placed;
    int cnt;
    logic run;
    placed = 0;
    while (placed < target) begin
      if ($urandom_range(99) < 5) offer_noise();
      if (rle) begin
        run = 1'($urandom_range(1));
        cnt = ($urandom_range(19) == 0) ? $urandom_range(127) : $urandom_range(6);
        offer_beat(ACT_DATA, {run, 7'(cnt)});
        offer_pixel(chans);
        placed++;
        for (int k = 0; k < cnt && placed < target; k++) begin
          if (run) begin
            // a byte sent while repeats wait is rejected
            if ($urandom_range(99) < 4) offer_beat(ACT_DATA, 8'($urandom_range(255)));
            offer_beat(ACT_STEP, 8'($urandom_range(255)));
          end else begin
            offer_pixel(chans);
          end
          placed++;
        end
      end else begin
        offer_pixel(chans);
        placed++;
      end
    end
    offer_beat(ACT_END, 8'($urandom_range(255)));
    if ($urandom_range(1)) offer_beat(ACT_DATA, 8'($urandom_range(255)));
  endtask

  // Wait until every expected result has been taken, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  function automatic int pick_side();
    int ext;
    if ($urandom_range(7) != 0) return $urandom_range(1, 8);
    ext = $urandom_range(3);
    if (ext == 0) return 0;
    if (ext == 1) return MAX_SIDE_DEF;
    if (ext == 2) return 32767;
    return $urandom_range(MAX_SIDE_DEF + 1, 32766);
  endfunction

  initial begin
    int sel;
    int ch;
    int w;
    int h;
    int rle;
    int flip;
    int chans;
    int total;
    int target;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults after reset: 4 channels, 1x1, raw
    offer_beat(ACT_UNUSED, 8'hFF);
    offer_beat(ACT_STEP, 8'h00);
    offer_beat(ACT_END, 8'h00);
    offer_beat(ACT_DATA, 8'h00);
    offer_beat(ACT_DATA, 8'hFF);
    offer_beat(ACT_DATA, 8'hA5);
    offer_beat(ACT_DATA, 8'h5A);
    offer_beat(ACT_DATA, 8'h33);
    offer_beat(ACT_END, 8'hFF);
    wait_drained();

    // Oversized registers, flipped rows: index near the top of its range,
    // byte rejected during a run, truncation with repeats waiting
    set_config(7, 32767, 32767, 1, 1);
    offer_beat(ACT_DATA, RUN_BIT | 8'd2);
    offer_beat(ACT_DATA, 8'h12);
    offer_beat(ACT_DATA, 8'h34);
    offer_beat(ACT_DATA, 8'h56);
    offer_beat(ACT_DATA, 8'h78);
    offer_beat(ACT_DATA, 8'hC3);
    offer_beat(ACT_END, 8'h00);
    offer_beat(ACT_STEP, 8'h00);
    offer_beat(ACT_STEP, 8'h00);
    offer_beat(ACT_DATA, 8'h00);
    repeat (4) offer_beat(ACT_DATA, 8'hFF);
    wait_drained();

    // Zero channels, 2x2 flipped: longest run crosses a row and overruns
    // the image; end of data is fine while repeats can still fill it
    set_config(0, 2, 2, 1, 1);
    offer_beat(ACT_DATA, 8'hFF);
    offer_beat(ACT_DATA, 8'h9C);
    offer_beat(ACT_END, 8'h00);
    repeat (4) offer_beat(ACT_STEP, 8'h00);
    offer_beat(ACT_DATA, 8'h11);
    offer_beat(ACT_END, 8'h00);
    wait_drained();

    // Random images under rotating idle patterns
    while (beats_sent < BEAT_TARGET) begin
      set_idling(phase % 4);
      sel  = $urandom_range(11);
      ch   = (sel < 8) ? (sel % 4) + 1 : ((sel == 8) ? 0 : sel - 4);
      w    = pick_side();
      h    = pick_side();
      rle  = ($urandom_range(3) != 0) ? 1 : 0;
      flip = $urandom_range(1);
      set_config(ch, w, h, rle, flip);
      if (phase == 0 || phase == 5) hold_requests <= hold_requests + 1;
      chans = (ch == 0) ? 1 : ((ch > 4) ? 4 : ch);
      total = side_of(w) * side_of(h);
      if (total > 64) target = $urandom_range(8, 20);
      else if ($urandom_range(9) == 0) target = $urandom_range(1, total);
      else target = total;
      feed_image(chans, target, rle != 0);
      wait_drained();
      phase++;
    end

    $display("Ran %0d input beats: directed corners plus %0d random image setups.",
             beats_sent, phase);
    $display("Checked %0d result beats, %0d of them pixel writes.",
             checked_count, pixel_count);
    if (fail_count == 0 && pending_results == 0) begin
      $display("tga_rle_pixel_decoder_tb passed");
    end else begin
      $display("tga_rle_pixel_decoder_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tga_rle_pkg.sv
rtl/tga_rle_pixel_decoder.sv
test/tga_rle_decode_checker.sv
test/tga_rle_pixel_decoder_tb.sv
